/* sv/assert_macros.svh */
// Assertion helpers shared by the MD5 engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The effect must hold in the cycle after the cause.
`define ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

/* sv/md5_pkg.sv */
`default_nettype none

package md5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] PAD_BYTE_WORD = 32'h00000080;
   localparam logic [3:0]  LEN_LO_SLOT   = 4'd14;
   localparam logic [3:0]  LAST_SLOT     = 4'd15;
   localparam logic [5:0]  LAST_ROUND    = 6'd63;

   // Source of the word written into the block buffer.
   typedef enum logic [2:0] {
      SEL_INPUT,
      SEL_PAD80,
      SEL_ZERO,
      SEL_LEN_LO,
      SEL_LEN_HI
   } word_sel_type;

   typedef struct packed {
      logic         push;
      word_sel_type word_sel;
      logic         round_en;
      logic [5:0]   round;
      logic         update_cv;
      logic         emit;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] fill_pos;
   } dp_status_type;

   // Number of bytes an item contributes: a non-last item always carries four.
   function automatic logic [2:0] sat_count(input logic [2:0] cnt, input logic last);
      logic [2:0] n;
      if (!last || cnt > 3'd4) begin
         n = 3'd4;
      end else begin
         n = cnt;
      end
      return n;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'h0: s = 5'd7;
         4'h1: s = 5'd12;
         4'h2: s = 5'd17;
         4'h3: s = 5'd22;
         4'h4: s = 5'd5;
         4'h5: s = 5'd9;
         4'h6: s = 5'd14;
         4'h7: s = 5'd20;
         4'h8: s = 5'd4;
         4'h9: s = 5'd11;
         4'hA: s = 5'd16;
         4'hB: s = 5'd23;
         4'hC: s = 5'd6;
         4'hD: s = 5'd10;
         4'hE: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] sine_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
         6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
         6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
         6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
         6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
         6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
         6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
         6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
         6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
         6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
         6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
         6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
         6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
         6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
         6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
         6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
         6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
         6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
         6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
         6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
         6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
         6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
         6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
         6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
         6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
         6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
         6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
         6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
         6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
         6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
         6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

/* sv/md5_dp.sv */
`default_nettype none

module md5_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire md5_pkg::dp_cmd_type cmd,
   output md5_pkg::dp_status_type   status,
   input  wire logic [31:0]        word,
   input  wire logic [2:0]         byte_count,
   input  wire logic               last,
   output logic [127:0]            digest
);

`include "assert_macros.svh"

   logic [31:0]  block_ff [16];
   logic [31:0]  cv_ff [4];
   logic [31:0]  cv_in [4];
   logic [31:0]  wv_ff [4];
   logic [31:0]  wv_in [4];
   logic [60:0]  bytes_ff, bytes_in;
   logic [3:0]   fill_ff, fill_in;
   logic [127:0] digest_ff;

   logic [2:0]   n;
   logic [31:0]  in_word;
   logic [31:0]  push_word;
   logic [1:0]   q;
   logic [3:0]   r4;
   logic [3:0]   g;
   logic [31:0]  f;
   logic [31:0]  t;
   logic [63:0]  rot_dbl;
   logic [31:0]  new_b;

   assign n = md5_pkg::sat_count(byte_count, last);

   // A short last word is masked and gets the pad byte right above its data.
   always_comb begin
      case (n)
         3'd1:    in_word = {16'h0000, 8'h80, word[7:0]};
         3'd2:    in_word = {8'h00, 8'h80, word[15:0]};
         3'd3:    in_word = {8'h80, word[23:0]};
         default: in_word = word;
      endcase
   end

   always_comb begin
      case (cmd.word_sel)
         md5_pkg::SEL_INPUT:  push_word = in_word;
         md5_pkg::SEL_PAD80:  push_word = md5_pkg::PAD_BYTE_WORD;
         md5_pkg::SEL_LEN_LO: push_word = {bytes_ff[28:0], 3'b000};
         md5_pkg::SEL_LEN_HI: push_word = bytes_ff[60:29];
         default:             push_word = 32'h0;
      endcase
   end

   // One MD5 round.
   assign q  = cmd.round[5:4];
   assign r4 = cmd.round[3:0];

   always_comb begin
      case (q)
         2'd0: begin
            f = (wv_ff[1] & wv_ff[2]) | (~wv_ff[1] & wv_ff[3]);
            g = r4;
         end
         2'd1: begin
            f = (wv_ff[1] & wv_ff[3]) | (wv_ff[2] & ~wv_ff[3]);
            g = 4'(r4 * 4'd5 + 4'd1);
         end
         2'd2: begin
            f = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
            g = 4'(r4 * 4'd3 + 4'd5);
         end
         default: begin
            f = wv_ff[2] ^ (wv_ff[1] | ~wv_ff[3]);
            g = 4'(r4 * 4'd7);
         end
      endcase
   end

   assign t       = wv_ff[0] + f + block_ff[g] + md5_pkg::sine_k(cmd.round);
   assign rot_dbl = {t, t} << md5_pkg::rot_amount(cmd.round);
   assign new_b   = wv_ff[1] + rot_dbl[63:32];

   always_comb begin
      cv_in    = cv_ff;
      wv_in    = wv_ff;
      bytes_in = bytes_ff;
      fill_in  = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + 4'd1;
         if (cmd.word_sel == md5_pkg::SEL_INPUT) begin
            bytes_in = bytes_ff + 61'(n);
         end
         // The block is full after this write: start from the chaining value.
         if (fill_ff == md5_pkg::LAST_SLOT) begin
            wv_in = cv_ff;
         end
      end
      if (cmd.round_en) begin
         wv_in[0] = wv_ff[3];
         wv_in[1] = new_b;
         wv_in[2] = wv_ff[1];
         wv_in[3] = wv_ff[2];
      end
      if (cmd.update_cv) begin
         for (int i = 0; i < 4; i++) begin
            cv_in[i] = cv_ff[i] + wv_ff[i];
         end
      end
      if (cmd.emit) begin
         cv_in    = '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
         bytes_in = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff    <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
         wv_ff    <= '{default: 32'h0};
         bytes_ff <= '0;
         fill_ff  <= '0;
      end else begin
         cv_ff    <= cv_in;
         wv_ff    <= wv_in;
         bytes_ff <= bytes_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         block_ff[fill_ff] <= push_word;
      end
      if (cmd.emit) begin
         digest_ff <= {cv_ff[3], cv_ff[2], cv_ff[1], cv_ff[0]};
      end
   end

   assign status.fill_pos = fill_ff;
   assign digest          = digest_ff;

   `ASSERT_NEXT(a_fill_wraps, clock, reset,
      cmd.push && !cmd.emit && (fill_ff == md5_pkg::LAST_SLOT), fill_ff == 4'd0,
      "block buffer did not wrap after its last slot")
   `ASSERT_HOLDS(a_no_push_in_rounds, clock, reset, !(cmd.push && cmd.round_en),
      "block buffer written while rounds run")

endmodule

`default_nettype wire

/* sv/md5_ctrl.sv */
`default_nettype none

module md5_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [2:0]           byte_count,
   input  wire logic                 last,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output md5_pkg::dp_cmd_type       cmd,
   input  wire md5_pkg::dp_status_type status
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_UPDATE,
      ST_PAD,
      ST_FINAL
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       need80_ff, need80_in;
   logic       lenlo_ff, lenlo_in;
   logic       pad_ff, pad_in;
   logic       final_ff, final_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic [2:0] n;
   logic       at_last_slot;

   assign n            = md5_pkg::sat_count(byte_count, last);
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign at_last_slot = (status.fill_pos == md5_pkg::LAST_SLOT);

   always_comb begin
      cmd           = '0;
      cmd.word_sel  = md5_pkg::SEL_ZERO;
      cmd.round     = round_ff;
      state_in      = state_ff;
      round_in      = round_ff;
      need80_in     = need80_ff;
      lenlo_in      = lenlo_ff;
      pad_in        = pad_ff;
      final_in      = final_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // An empty last item writes nothing and only pads.
               cmd.push     = !(last && n == 3'd0);
               cmd.word_sel = md5_pkg::SEL_INPUT;
               if (last) begin
                  pad_in    = 1'b1;
                  need80_in = (n == 3'd0) || (n == 3'd4);
               end
               if (cmd.push && at_last_slot) begin
                  state_in = ST_COMPRESS;
               end else if (last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            if (need80_ff) begin
               cmd.word_sel = md5_pkg::SEL_PAD80;
               need80_in    = 1'b0;
            end else if (lenlo_ff) begin
               cmd.word_sel = md5_pkg::SEL_LEN_HI;
               final_in     = 1'b1;
            end else if (status.fill_pos == md5_pkg::LEN_LO_SLOT) begin
               cmd.word_sel = md5_pkg::SEL_LEN_LO;
               lenlo_in     = 1'b1;
            end
            if (at_last_slot) begin
               state_in = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_cv = 1'b1;
            if (final_ff) begin
               state_in = ST_FINAL;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FINAL: begin
            // Wait until the output register is free.
            cmd.emit = !rsp_valid_ff || rsp_tready;
            if (cmd.emit) begin
               rsp_valid_in = 1'b1;
               pad_in       = 1'b0;
               final_in     = 1'b0;
               lenlo_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         need80_ff    <= 1'b0;
         lenlo_ff     <= 1'b0;
         pad_ff       <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         need80_ff    <= need80_in;
         lenlo_ff     <= lenlo_in;
         pad_ff       <= pad_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_HOLDS(a_round_idle, clock, reset,
      (state_ff != ST_COMPRESS) |-> (round_ff == 6'd0),
      "round counter left nonzero outside compression")
   `ASSERT_HOLDS(a_emit_slot_free, clock, reset,
      cmd.emit |-> (!rsp_valid_ff || rsp_tready),
      "digest overwritten before its transfer")
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff,
      "digest loaded without raising valid")

endmodule

`default_nettype wire

/* sv/md5_digest_engine_core.sv */
// Channel   Direction  Signals                         Contents
// req       in         req_tvalid/tready/tdata/tlast   word, byte_count, last
// rsp       out        rsp_tvalid/tready/tdata         digest_low, digest_high
//
// A message word is taken only while the engine is idle. Every 16th word starts a compression
// of 64 rounds at one round per cycle in a single round unit, followed by a fold into the
// chaining value; no word is taken until that block is done.
// The last item adds the padding words, a compression for each block they fill and
// a load of the digest register.
// Synchronous active-high reset loads the initial vector and empties the buffer.
// Input continues while a digest waits; the next digest waits for its transfer.
`default_nettype none

module md5_digest_engine_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // word [31:0], byte_count [34:32], zero fill
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // digest_low [63:0], digest_high [127:64]
);

   md5_pkg::dp_cmd_type    cmd;
   md5_pkg::dp_status_type status;

   md5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .byte_count (req_tdata[34:32]),
      .last       (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   md5_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .word       (req_tdata[31:0]),
      .byte_count (req_tdata[34:32]),
      .last       (req_tlast),
      .digest     (rsp_tdata)
   );

endmodule

`default_nettype wire
